>>> rtl/wdtf_pkg.sv
// ----------------------------------------------------------------------------
// wdtf_pkg
// Shared types, constants and helper functions of the word deleting text
// filter: window geometry, scan flags, delimiter test and count saturation.
// ----------------------------------------------------------------------------
package wdtf_pkg;

	localparam int MAX_WORD   = 8;
	localparam int COUNT_BITS = 16;
	localparam int WIN_DEPTH  = MAX_WORD + 1;
	localparam int WIN_W      = 8 * WIN_DEPTH;
	localparam int WORD_W     = 8 * MAX_WORD;
	localparam int FILL_W     = $clog2(WIN_DEPTH + 1);
	localparam int WLEN_W     = 4;
	localparam int OUT_CNT_W  = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int NUM_DELIMS = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WORD_BYTES  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_LENGTH = 1'b1;

	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// space , . ? : ; ( )
	localparam logic [7:0] DELIMS [NUM_DELIMS] = '{
		8'h20, 8'h2C, 8'h2E, 8'h3F, 8'h3A, 8'h3B, 8'h28, 8'h29
	};

	typedef logic [FILL_W-1:0]     fill_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [WIN_W-1:0]      win_t;

	// scan state carried from one head decision to the next
	typedef struct packed {
		logic   skip;          // byte right after a deleted word: no match try
		logic   space_before;  // last kept byte was a space, or start of text
		logic   in_token;
		count_t deleted;
		count_t tokens;
	} scan_t;

	localparam scan_t SCAN_RESET = '{
		skip: 1'b0, space_before: 1'b1, in_token: 1'b0, deleted: '0, tokens: '0
	};

	// outcome of one head decision
	typedef struct packed {
		logic       emit;       // head byte kept (else the word was deleted)
		logic [7:0] head_byte;
		fill_t      fill;
		scan_t      scan;
	} head_res_t;

	function automatic logic is_delim(logic [7:0] c);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < NUM_DELIMS; i++) begin
			if (c == DELIMS[i])
				hit = 1'b1;
		end
		return hit;
	endfunction

	// word length clamped to 1..MAX_WORD
	function automatic fill_t eff_len(logic [WLEN_W-1:0] wl);
		fill_t n;
		if (wl == '0)
			n = fill_t'(1);
		else if (int'(wl) > MAX_WORD)
			n = fill_t'(MAX_WORD);
		else
			n = fill_t'(wl);
		return n;
	endfunction

	function automatic count_t sat_inc(count_t c);
		return (&c) ? c : c + 1'b1;
	endfunction

endpackage

>>> rtl/wdtf_head.sv
// ----------------------------------------------------------------------------
// wdtf_head
// One decision on the head of the window: either the configured word sits
// at the head (after a space or at the start, followed by a delimiter or by
// the end) and is dropped, or the head byte is kept and leaves the window.
// ----------------------------------------------------------------------------
module wdtf_head (
	input  wdtf_pkg::win_t                  win,
	input  wdtf_pkg::fill_t                 fill,
	input  wdtf_pkg::scan_t                 scan,
	input  logic [wdtf_pkg::WORD_W-1:0]     word,
	input  wdtf_pkg::fill_t                 len,
	input  logic                            at_end,
	output wdtf_pkg::win_t                  win_nx,
	output wdtf_pkg::head_res_t             res
);
	import wdtf_pkg::*;

	logic [MAX_WORD-1:0] byte_eq;
	logic [7:0]          after_word;
	logic                tail_ok;
	logic                match;
	fill_t               drop;

	// byte compare against the word, bytes past the length always agree
	always_comb begin
		for (int i = 0; i < MAX_WORD; i++) begin
			byte_eq[i] = (win[8*i +: 8] == word[8*i +: 8]) || (i >= int'(len));
		end
	end

	// character right behind the word candidate
	always_comb begin
		after_word = '0;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			if (len == fill_t'(i))
				after_word = win[8*i +: 8];
		end
	end

	assign tail_ok = (fill > len) ? is_delim(after_word) : at_end;
	assign match   = !scan.skip && scan.space_before && (fill >= len) &&
	                 (&byte_eq) && tail_ok;
	assign drop    = match ? len : fill_t'(1);
	assign win_nx  = win >> {drop, 3'b000};

	// scan flags and counters after the decision
	always_comb begin
		res.emit      = !match;
		res.head_byte = win[7:0];
		res.fill      = fill - drop;
		res.scan      = scan;
		if (match) begin
			res.scan.deleted = sat_inc(scan.deleted);
			res.scan.skip    = 1'b1;
		end else begin
			res.scan.skip         = 1'b0;
			res.scan.space_before = (win[7:0] == CHAR_SPACE);
			if (is_delim(win[7:0])) begin
				res.scan.in_token = 1'b0;
			end else if (!scan.in_token) begin
				res.scan.in_token = 1'b1;
				res.scan.tokens   = sat_inc(scan.tokens);
			end
		end
	end

endmodule

>>> rtl/word_deleting_text_filter.sv
// ----------------------------------------------------------------------------
// word_deleting_text_filter
// A kept byte is decided once the window holds word length plus one bytes
// and is registered to the output; one byte per cycle while the output does
// not stall. A last input flushes the window, one head decision per cycle
// as output moves, then the final result with counts; no input taken meanwhile.
// Reset clears the window, scan flags and counts; word_length resets to 1.
// ----------------------------------------------------------------------------
module word_deleting_text_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wdtf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wdtf_pkg::WORD_W-1:0]         cfg_data,
	// input text
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          in_byte,
	input  logic                                in_last,
	// filtered text
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          out_byte,
	output logic                                byte_valid,
	output logic [wdtf_pkg::OUT_CNT_W-1:0]      deleted_count,
	output logic [wdtf_pkg::OUT_CNT_W-1:0]      token_count,
	output logic                                out_last
);
	import wdtf_pkg::*;

	logic [WORD_W-1:0] word_bytes_q;
	logic [WLEN_W-1:0] word_length_q;

	win_t      win_q;
	fill_t     fill_q;
	scan_t     scan_q;
	logic      flush_q;
	logic      hold_vld_q;
	logic [7:0] hold_byte_q;

	logic                 out_vld_q;
	logic [7:0]           out_byte_q;
	logic                 byte_valid_q;
	logic [OUT_CNT_W-1:0] deleted_q;
	logic [OUT_CNT_W-1:0] token_q;
	logic                 out_last_q;

	fill_t     len;
	win_t      head_win;
	head_res_t head;
	logic      adv;
	logic      need;
	logic      fin;
	logic      do_step;
	logic      accept;

	win_t                 base_win;
	fill_t                base_fill;
	scan_t                base_scan;
	logic [FILL_W+2:0]    pos;
	win_t                 win_d;
	fill_t                fill_d;
	scan_t                scan_d;
	logic                 flush_d;

	logic [7:0]           ob_d;
	logic                 bv_d;
	logic [OUT_CNT_W-1:0] del_d;
	logic [OUT_CNT_W-1:0] tok_d;
	logic                 last_d;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_bytes_q  <= '0;
			word_length_q <= WLEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WORD_BYTES:  word_bytes_q  <= cfg_data;
				REG_WORD_LENGTH: word_length_q <= cfg_data[WLEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign len = eff_len(word_length_q);

	wdtf_head u_head (
		.win    (win_q),
		.fill   (fill_q),
		.scan   (scan_q),
		.word   (word_bytes_q),
		.len    (len),
		.at_end (flush_q),
		.win_nx (head_win),
		.res    (head)
	);

	// step control: one head decision per cycle when the output can move
	assign adv     = !out_vld_q || !out_stall;
	assign need    = flush_q ? (fill_q != '0) : (fill_q > len);
	assign fin     = flush_q && (fill_q == '0);
	assign do_step = need && adv;

	// take a byte once the window needs no further decision
	assign in_stall = flush_q || (need && !(adv && !(head.fill > len)));
	assign accept   = in_valid && !in_stall;

	// window and scan state update
	always_comb begin
		base_win  = win_q;
		base_fill = fill_q;
		base_scan = scan_q;
		if (do_step) begin
			base_win  = head_win;
			base_fill = head.fill;
			base_scan = head.scan;
		end
		win_d   = base_win;
		fill_d  = base_fill;
		scan_d  = base_scan;
		flush_d = flush_q;
		pos     = {base_fill, 3'b000};
		if (accept) begin
			win_d   = (base_win & ~(WIN_W'(8'hFF) << pos)) | (WIN_W'(in_byte) << pos);
			fill_d  = base_fill + 1'b1;
			flush_d = in_last;
		end
		if (fin && adv) begin
			fill_d  = '0;
			scan_d  = SCAN_RESET;
			flush_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			scan_q  <= SCAN_RESET;
			flush_q <= 1'b0;
		end else begin
			fill_q  <= fill_d;
			scan_q  <= scan_d;
			flush_q <= flush_d;
		end
	end

	always_ff @(posedge clk) begin
		win_q <= win_d;
	end

	// result payload: kept byte, held flush byte, or final result with counts
	always_comb begin
		if (fin) begin
			ob_d   = hold_vld_q ? hold_byte_q : '0;
			bv_d   = hold_vld_q;
			del_d  = OUT_CNT_W'(scan_q.deleted);
			tok_d  = OUT_CNT_W'(scan_q.tokens);
			last_d = 1'b1;
		end else begin
			ob_d   = flush_q ? hold_byte_q : head.head_byte;
			bv_d   = 1'b1;
			del_d  = '0;
			tok_d  = '0;
			last_d = 1'b0;
		end
	end

	// output register and flush hold stage; the hold keeps the newest kept
	// byte of a flush back until it is known whether it is the final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			hold_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b0;
			if (fin) begin
				out_vld_q  <= 1'b1;
				hold_vld_q <= 1'b0;
			end else if (do_step && head.emit) begin
				if (!flush_q) begin
					out_vld_q <= 1'b1;
				end else begin
					out_vld_q  <= hold_vld_q;
					hold_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q   <= ob_d;
			byte_valid_q <= bv_d;
			deleted_q    <= del_d;
			token_q      <= tok_d;
			out_last_q   <= last_d;
			if (do_step && head.emit && flush_q)
				hold_byte_q <= head.head_byte;
		end
	end

	assign out_valid     = out_vld_q;
	assign out_byte      = out_byte_q;
	assign byte_valid    = byte_valid_q;
	assign deleted_count = deleted_q;
	assign token_count   = token_q;
	assign out_last      = out_last_q;

endmodule

>>> sim/word_deleting_text_filter_tb.sv
// ----------------------------------------------------------------------------
// word_deleting_text_filter_tb
// Self-checking bench for the word deleting text filter. Texts are streamed
// one byte per transaction under several word settings and idle patterns.
// A scoreboard predicts kept bytes, end-of-text counts and flush behavior,
// and compares each output transaction in order.
// ----------------------------------------------------------------------------
module word_deleting_text_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wdtf_pkg::*;

	localparam int unsigned COUNT_MAX     = 2**COUNT_BITS - 1;
	localparam int          SETTING_ITEMS = 50;
	localparam int          LONG_HOLD     = 300;
	localparam int          SETTLE        = 2 * WIN_DEPTH + 4;

	typedef logic [7:0] text_t[$];

	// one output transaction
	typedef struct packed {
		logic [7:0]           ch;
		logic                 ch_valid;
		logic [OUT_CNT_W-1:0] deleted;
		logic [OUT_CNT_W-1:0] tokens;
		logic                 done;
	} filt_result_t;

	// ------------------------------------------------------------------------
	// Scoreboard: tracks the filter state and the queue of pending bytes
	// ------------------------------------------------------------------------
	class filter_scoreboard;
		logic [WORD_W-1:0] word_bytes;
		logic [WLEN_W-1:0] word_length;
		logic [7:0]        win [WIN_DEPTH];
		int unsigned       fill;
		bit                skip_next;
		bit                space_before;
		bit                in_token;
		int unsigned       deleted;
		int unsigned       tokens;
		filt_result_t      expected_q[$];
		int unsigned       errors;
		int unsigned       checked;
		int unsigned       texts;
		int unsigned       words_gone;

		function new();
			word_bytes  = '0;
			word_length = 1;
			errors      = 0;
			checked     = 0;
			texts       = 0;
			words_gone  = 0;
			clear_text();
		endfunction

		function void clear_text();
			fill         = 0;
			skip_next    = 0;
			space_before = 1;
			in_token     = 0;
			deleted      = 0;
			tokens       = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
			if (idx == REG_WORD_BYTES)
				word_bytes = data;
			else
				word_length = data[WLEN_W-1:0];
		endfunction

		function int unsigned eff_word_len();
			if (word_length == 0)
				return 1;
			if (word_length > MAX_WORD)
				return MAX_WORD;
			return word_length;
		endfunction

		function bit is_separator(logic [7:0] c);
			case (c)
				" ", ",", ".", "?", ":", ";", "(", ")": return 1;
				default: return 0;
			endcase
		endfunction

		function void drop_front(int unsigned n);
			if (n > fill)
				n = fill;
			for (int i = 0; i + n < fill; i++)
				win[i] = win[i + n];
			fill -= n;
		endfunction

		// decide on the window head: 1 when a byte is kept, 0 when the word went
		function bit decide_head(bit at_end, output logic [7:0] kept);
			int unsigned len;
			bit hit;
			len = eff_word_len();
			hit = 0;
			kept = '0;
			if (!skip_next && space_before && fill >= len) begin
				hit = 1;
				for (int i = 0; i < len; i++)
					if (win[i] != word_bytes[8*i +: 8])
						hit = 0;
				if (hit)
					hit = (fill > len) ? is_separator(win[len]) : at_end;
			end
			if (hit) begin
				if (deleted < COUNT_MAX)
					deleted++;
				drop_front(len);
				skip_next = 1;
				return 0;
			end
			kept = win[0];
			drop_front(1);
			skip_next    = 0;
			space_before = (kept == CHAR_SPACE);
			if (is_separator(kept))
				in_token = 0;
			else if (!in_token) begin
				in_token = 1;
				if (tokens < COUNT_MAX)
					tokens++;
			end
			return 1;
		endfunction

		// accepted input byte: work out every result it causes
		function void note_input(logic [7:0] ch, logic done);
			filt_result_t batch [WIN_DEPTH];
			logic [7:0]   kept;
			int           n;
			n = 0;
			if (fill >= WIN_DEPTH)
				drop_front(fill - (WIN_DEPTH - 1));
			win[fill] = ch;
			fill++;
			if (!done) begin
				while (fill >= eff_word_len() + 1 && n < WIN_DEPTH)
					if (decide_head(1'b0, kept)) begin
						batch[n] = '{kept, 1'b1, '0, '0, 1'b0};
						n++;
					end
			end else begin
				while (fill > 0 && n < WIN_DEPTH)
					if (decide_head(1'b1, kept)) begin
						batch[n] = '{kept, 1'b1, '0, '0, 1'b0};
						n++;
					end
				// nothing kept: a bare transaction carries the counts
				if (n == 0) begin
					batch[0] = '0;
					n = 1;
				end
				batch[n-1].deleted = OUT_CNT_W'(deleted);
				batch[n-1].tokens  = OUT_CNT_W'(tokens);
				batch[n-1].done    = 1'b1;
				words_gone += deleted;
				texts++;
				clear_text();
			end
			for (int i = 0; i < n; i++)
				expected_q.push_back(batch[i]);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("ERROR @%0t: %s", $time, msg);
		endfunction

		function void check_result(filt_result_t got);
			filt_result_t want;
			if (expected_q.size() == 0) begin
				flag($sformatf("unexpected transaction: byte %02h valid %0b del %0d tok %0d last %0b",
					got.ch, got.ch_valid, got.deleted, got.tokens, got.done));
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got !== want)
				flag($sformatf({"result %0d: exp byte %02h/%0b del %0d tok %0d last %0b, ",
					"got byte %02h/%0b del %0d tok %0d last %0b"}, checked,
					want.ch, want.ch_valid, want.deleted, want.tokens, want.done,
					got.ch, got.ch_valid, got.deleted, got.tokens, got.done));
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT and signals
	// ------------------------------------------------------------------------
	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           in_byte;
	logic                 in_last;
	logic                 out_valid;
	logic                 out_stall;
	logic [7:0]           out_byte;
	logic                 byte_valid;
	logic [OUT_CNT_W-1:0] deleted_count;
	logic [OUT_CNT_W-1:0] token_count;
	logic                 out_last;

	word_deleting_text_filter uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.in_last(in_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.byte_valid(byte_valid),
		.deleted_count(deleted_count),
		.token_count(token_count),
		.out_last(out_last)
	);

	filter_scoreboard sb = new();

	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_req;
	int          hold_left;
	int unsigned settings_run;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Output side: check transactions, random stall, long hold-off on request
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : drain
		filt_result_t seen;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen = '{out_byte, byte_valid, deleted_count, token_count, out_last};
				sb.check_result(seen);
			end
			if (hold_req) begin
				hold_left = LONG_HOLD;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else
				out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Input side helpers
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic done);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= done;
		do @(posedge clk); while (in_stall);
		sb.note_input(b, done);
	endtask

	task automatic send_text(ref text_t t, input bit close);
		for (int i = 0; i < t.size(); i++)
			send_byte(t[i], close && (i == t.size() - 1));
	endtask

	// valid stays up after the write; the caller drops it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	// drain everything, let a silent window settle, then load a new word
	task automatic configure(input logic [WORD_W-1:0] word, input logic [WLEN_W-1:0] len);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		write_reg(REG_WORD_BYTES, word);
		write_reg(REG_WORD_LENGTH, WORD_W'(len));
		cfg_valid <= 1'b0;
		settings_run++;
	endtask

	function automatic logic [WORD_W-1:0] pack_word(string s);
		logic [WORD_W-1:0] w;
		w = '0;
		for (int i = 0; i < s.len() && i < MAX_WORD; i++)
			w[8*i +: 8] = s[i];
		return w;
	endfunction

	function automatic void push_str(ref text_t t, input string s);
		for (int i = 0; i < s.len(); i++)
			t.push_back(s[i]);
	endfunction

	function automatic logic [7:0] rand_letter();
		return 8'("a") + 8'($urandom_range(25));
	endfunction

	// random text built mostly from the current word, near misses and separators
	function automatic void build_text(ref text_t t);
		int n_tok;
		int kind;
		int wl;
		int sep;
		t.delete();
		wl = sb.eff_word_len();
		n_tok = $urandom_range(1, 6);
		for (int k = 0; k < n_tok; k++) begin
			kind = $urandom_range(99);
			if (kind < 45) begin
				for (int i = 0; i < wl; i++)
					t.push_back(sb.word_bytes[8*i +: 8]);
			end else if (kind < 55) begin
				// word with a trailing letter
				for (int i = 0; i < wl; i++)
					t.push_back(sb.word_bytes[8*i +: 8]);
				t.push_back(rand_letter());
			end else if (kind < 62) begin
				// truncated word
				for (int i = 0; i < wl - 1; i++)
					t.push_back(sb.word_bytes[8*i +: 8]);
				if (wl == 1)
					t.push_back(rand_letter());
			end else if (kind < 90) begin
				repeat ($urandom_range(1, 5)) t.push_back(rand_letter());
			end else begin
				repeat ($urandom_range(1, 3)) t.push_back(8'($urandom_range(255)));
			end
			sep = $urandom_range(99);
			if (sep < 50)
				t.push_back(CHAR_SPACE);
			else if (sep < 80)
				t.push_back(DELIMS[$urandom_range(NUM_DELIMS - 1)]);
			else if (sep < 92) begin
				t.push_back(DELIMS[$urandom_range(NUM_DELIMS - 1)]);
				t.push_back(CHAR_SPACE);
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		text_t             text_q;
		int                sent;
		logic [WORD_W-1:0] word;
		int                wl;

		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_WORD_BYTES;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		in_byte   <= '0;
		in_last   <= 1'b0;
		out_stall <= 1'b0;
		hold_req      = 0;
		hold_left     = 0;
		settings_run  = 0;
		send_idle_pct = 8;
		recv_idle_pct = 86;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: word at start, after space, inside brackets, at end,
		// a text that deletes everything, zero and all-ones bytes
		configure(pack_word("cat"), 3);
		text_q.delete();
		push_str(text_q, "cat cat,a(cat)");
		send_text(text_q, 1);
		text_q.delete();
		push_str(text_q, "cat");
		send_text(text_q, 1);
		text_q.delete();
		text_q.push_back(8'h00);
		text_q.push_back(8'hFF);
		push_str(text_q, " cat");
		send_text(text_q, 1);

		// random texts under a sequence of word settings
		for (int s = 0; s < 6; s++) begin
			case (s / 2)
				0: begin send_idle_pct = 8;  recv_idle_pct = 86; end
				1: begin send_idle_pct = 86; recv_idle_pct = 8;  end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			case (s)
				0: configure(pack_word("the"), 3);
				1: configure('1, 4'd15);
				2: configure('0, 4'd0);
				3: begin
					word = '0;
					for (int i = 0; i < MAX_WORD; i++)
						word[8*i +: 8] = rand_letter();
					configure(word, 4'd8);
				end
				4: configure(pack_word("ab"), 4'd2);
				default: begin
					wl = $urandom_range(1, MAX_WORD);
					word = {$urandom, $urandom};
					for (int i = 0; i < wl; i++)
						word[8*i +: 8] = rand_letter();
					configure(word, 4'(wl));
				end
			endcase
			// output held off for a long stretch so the input backs up
			if (s == 4)
				hold_req = 1;
			sent = 0;
			while (sent < SETTING_ITEMS) begin
				build_text(text_q);
				send_text(text_q, 1);
				sent += text_q.size();
			end
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Run covered %0d texts under %0d word settings, %0d output transactions checked.",
			sb.texts, settings_run, sb.checked);
		$display("Words deleted in total: %0d; mismatches: %0d.", sb.words_gone, sb.errors);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> filelist.f
rtl/wdtf_pkg.sv
rtl/wdtf_head.sv
rtl/word_deleting_text_filter.sv
sim/word_deleting_text_filter_tb.sv
